// File: rtl/core/gnmp_pkg.sv
// Shared types and constants for the GNSS NMEA/UBX frame parser.
// No dependencies; imported by every module of the block.
package gnmp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] SyncFirstRst     = 8'hB5;
  localparam logic [ByteW-1:0] SyncSecondRst    = 8'h62;
  localparam logic [ByteW-1:0] SentenceStartRst = 8'h24;

  localparam logic [ByteW-1:0] ChCr = 8'h0D;
  localparam logic [ByteW-1:0] ChLf = 8'h0A;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST     = 2'd0,
    CFG_SYNC_SECOND    = 2'd1,
    CFG_SENTENCE_START = 2'd2
  } cfg_idx_t;

  typedef enum logic [KindW-1:0] {
    KIND_NMEA    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    M_HUNT    = 4'd0,
    M_NMEA    = 4'd1,
    M_SYNC2   = 4'd2,
    M_CLASS   = 4'd3,
    M_ID      = 4'd4,
    M_LEN_LO  = 4'd5,
    M_LEN_HI  = 4'd6,
    M_PAYLOAD = 4'd7,
    M_CK_A    = 4'd8,
    M_CK_B    = 4'd9
  } mode_t;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] sentence_start;
  } cfg_t;

  typedef struct packed {
    kind_t            item_kind;
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic             check_ok;
    logic [ByteW-1:0] msg_class;
    logic [ByteW-1:0] msg_id;
    logic [LenW-1:0]  payload_len;
  } res_t;

endpackage

// File: rtl/core/gnmp_parser.sv
// Per-word frame state machine: mode, checksum sums and frame header fields.
// Depends on gnmp_pkg; produces at most one result word per accepted word.
module gnmp_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [gnmp_pkg::ByteW-1:0] data_byte,
  input  gnmp_pkg::cfg_t          cfg,
  output logic                    res_valid,
  output gnmp_pkg::res_t          res
);
  import gnmp_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic             prev_cr_r, prev_cr_nxt;
  logic [ByteW-1:0] class_r, class_nxt;
  logic [ByteW-1:0] id_r, id_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic [LenW-1:0]  left_r, left_nxt;
  logic [ByteW-1:0] sum_a_r, sum_a_nxt;
  logic [ByteW-1:0] sum_b_r, sum_b_nxt;
  logic [ByteW-1:0] rsa_r, rsa_nxt;

  logic             hunt_start;
  logic             hunt_sync;
  logic             nmea_end;
  logic [ByteW-1:0] add_a;
  logic [ByteW-1:0] add_b;
  logic [LenW-1:0]  len_full;

  assign hunt_start = (data_byte == cfg.sentence_start);
  assign hunt_sync  = (data_byte == cfg.sync_first);
  assign nmea_end   = (data_byte == ChLf) && prev_cr_r;
  assign add_a      = sum_a_r + data_byte;
  assign add_b      = sum_b_r + add_a;
  assign len_full   = {data_byte, len_r[ByteW-1:0]};

  always_comb begin
    unique case (mode_r)
      M_NMEA:    mode_nxt = nmea_end ? M_HUNT : M_NMEA;
      M_SYNC2: begin
        priority if (data_byte == cfg.sync_second) mode_nxt = M_CLASS;
        else if (hunt_start)                       mode_nxt = M_NMEA;
        else if (hunt_sync)                        mode_nxt = M_SYNC2;
        else                                       mode_nxt = M_HUNT;
      end
      M_CLASS:   mode_nxt = M_ID;
      M_ID:      mode_nxt = M_LEN_LO;
      M_LEN_LO:  mode_nxt = M_LEN_HI;
      M_LEN_HI:  mode_nxt = (len_full == '0) ? M_CK_A : M_PAYLOAD;
      M_PAYLOAD: mode_nxt = (left_r == LenW'(1)) ? M_CK_A : M_PAYLOAD;
      M_CK_A:    mode_nxt = M_CK_B;
      M_CK_B:    mode_nxt = M_HUNT;
      default: begin
        priority if (hunt_start) mode_nxt = M_NMEA;
        else if (hunt_sync)      mode_nxt = M_SYNC2;
        else                     mode_nxt = M_HUNT;
      end
    endcase
  end

  always_comb begin
    prev_cr_nxt = prev_cr_r;
    class_nxt   = class_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    rsa_nxt     = rsa_r;
    res_valid   = 1'b0;
    res         = '0;
    res.item_kind = KIND_NMEA;
    unique case (mode_r)
      M_NMEA: begin
        res_valid    = 1'b1;
        res.out_byte = data_byte;
        res.last     = nmea_end;
        prev_cr_nxt  = nmea_end ? 1'b0 : (data_byte == ChCr);
      end
      M_SYNC2: begin
        priority if (data_byte == cfg.sync_second) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end else if (hunt_start) begin
          res_valid    = 1'b1;
          res.out_byte = data_byte;
          prev_cr_nxt  = (data_byte == ChCr);
        end else begin
          prev_cr_nxt = prev_cr_r;
        end
      end
      M_CLASS: begin
        class_nxt = data_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
      end
      M_ID: begin
        id_nxt    = data_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
      end
      M_LEN_LO: begin
        len_nxt   = {{(LenW-ByteW){1'b0}}, data_byte};
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
      end
      M_LEN_HI: begin
        len_nxt   = len_full;
        left_nxt  = len_full;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
      end
      M_PAYLOAD: begin
        sum_a_nxt       = add_a;
        sum_b_nxt       = add_b;
        left_nxt        = left_r - LenW'(1);
        res_valid       = 1'b1;
        res.item_kind   = KIND_PAYLOAD;
        res.out_byte    = data_byte;
        res.msg_class   = class_r;
        res.msg_id      = id_r;
        res.payload_len = len_r;
      end
      M_CK_A: rsa_nxt = data_byte;
      M_CK_B: begin
        res_valid       = 1'b1;
        res.item_kind   = KIND_SUMMARY;
        res.last        = 1'b1;
        res.check_ok    = (rsa_r == sum_a_r) && (data_byte == sum_b_r);
        res.msg_class   = class_r;
        res.msg_id      = id_r;
        res.payload_len = len_r;
      end
      default: begin
        if (hunt_start) begin
          res_valid    = 1'b1;
          res.out_byte = data_byte;
          prev_cr_nxt  = (data_byte == ChCr);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_HUNT;
      prev_cr_r <= 1'b0;
      class_r   <= '0;
      id_r      <= '0;
      len_r     <= '0;
      left_r    <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      rsa_r     <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      prev_cr_r <= prev_cr_nxt;
      class_r   <= class_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      rsa_r     <= rsa_nxt;
    end
  end

endmodule

// File: rtl/core/gnmp_outbuf.sv
// Output register with one skid entry for result words.
// Depends on gnmp_pkg for the result word type.
module gnmp_outbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gnmp_pkg::res_t push_res,
  input  logic           out_stall,
  output logic           out_valid,
  output gnmp_pkg::res_t out_res,
  output logic           full
);
  import gnmp_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic pop;

  assign pop       = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign full      = skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    priority if (skid_valid_r) begin
      if (pop) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

// File: rtl/core/gnss_nmea_ubx_frame_parser.sv
// Top level of the GNSS NMEA/UBX frame parser.
// Depends on gnmp_pkg, gnmp_parser and gnmp_outbuf.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data_byte) takes one received byte
//   per word. NMEA sentence bytes come out as kind NMEA, the line feed after
//   a carriage return flagged last. UBX payload bytes come out as kind
//   PAYLOAD, followed by one SUMMARY word (last set, check_ok from Fletcher
//   checksum). Bytes while hunting, other than the sentence start character,
//   and frame header/checksum bytes give no output word.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the sync
//   pair and the sentence start character; cfg_ready is always high. Write
//   it only while the block is idle.
// Timing:
//   One byte accepted per cycle while in_stall is low; each result word is
//   registered in the output buffer. The state machine decides each byte
//   combinationally: one byte per clock sustained while out_stall is low.
// Reset and stall:
//   Synchronous reset returns the parser to hunting, clears output valid and
//   reloads default config values. When out_stall holds a word, one more
//   result is caught in the skid entry; in_stall then rises until it drains.
module gnss_nmea_ubx_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gnmp_pkg::ByteW-1:0]    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gnmp_pkg::KindW-1:0]    out_item_kind,
  output logic [gnmp_pkg::ByteW-1:0]    out_out_byte,
  output logic                          out_last,
  output logic                          out_check_ok,
  output logic [gnmp_pkg::ByteW-1:0]    out_msg_class,
  output logic [gnmp_pkg::ByteW-1:0]    out_msg_id,
  output logic [gnmp_pkg::LenW-1:0]     out_payload_len,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gnmp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gnmp_pkg::ByteW-1:0]    cfg_data
);
  import gnmp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic in_accept;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic buf_full;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = buf_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_FIRST:     cfg_nxt.sync_first     = cfg_data;
        CFG_SYNC_SECOND:    cfg_nxt.sync_second    = cfg_data;
        CFG_SENTENCE_START: cfg_nxt.sentence_start = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first     <= SyncFirstRst;
      cfg_r.sync_second    <= SyncSecondRst;
      cfg_r.sentence_start <= SentenceStartRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gnmp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  gnmp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && res_valid),
    .push_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign out_item_kind   = out_res.item_kind;
  assign out_out_byte    = out_res.out_byte;
  assign out_last        = out_res.last;
  assign out_check_ok    = out_res.check_ok;
  assign out_msg_class   = out_res.msg_class;
  assign out_msg_id      = out_res.msg_id;
  assign out_payload_len = out_res.payload_len;

endmodule

// File: rtl/core/gnmp_checker.sv
// Port-level checks for the GNSS NMEA/UBX frame parser, bound to the top.
// Depends on gnmp_pkg and gnss_nmea_ubx_frame_parser.
module gnmp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [gnmp_pkg::KindW-1:0]   out_item_kind,
  input logic [gnmp_pkg::ByteW-1:0]   out_out_byte,
  input logic                         out_last,
  input logic                         out_check_ok,
  input logic [gnmp_pkg::ByteW-1:0]   out_msg_class,
  input logic [gnmp_pkg::ByteW-1:0]   out_msg_id,
  input logic [gnmp_pkg::LenW-1:0]    out_payload_len
);
  import gnmp_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped under stall");

  a_nmea_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_NMEA |->
      !out_check_ok && out_msg_class == '0 && out_msg_id == '0 && out_payload_len == '0)
    else $error("NMEA word carries frame fields");

  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_SUMMARY |-> out_last && out_out_byte == '0)
    else $error("summary word malformed");

  a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_PAYLOAD |-> !out_last && !out_check_ok &&
      out_payload_len != '0)
    else $error("payload word malformed");

endmodule

bind gnss_nmea_ubx_frame_parser gnmp_checker u_gnmp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_item_kind   (out_item_kind),
  .out_out_byte    (out_out_byte),
  .out_last        (out_last),
  .out_check_ok    (out_check_ok),
  .out_msg_class   (out_msg_class),
  .out_msg_id      (out_msg_id),
  .out_payload_len (out_payload_len)
);
